@@ src/assert_macros.svh @@
// Shared assertion macros, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk.
`define QPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define QPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/qpt_pkg.sv @@
package qpt_pkg;

    localparam int N_W        = 15;
    localparam int D_W        = 13;
    localparam int PINS_W     = 2;
    localparam int REF_W      = 16;
    localparam int POS_W      = 14;
    localparam int ANG_W      = 12;
    localparam int DIF_W      = 14;
    localparam int CNT_W      = 15;
    localparam int SUM_W      = 16;
    localparam int PROD_W     = 28;
    localparam int DIV_W      = 27;
    localparam int REM_W      = 17;
    localparam int MAG_W      = 16;
    localparam int STEPS_W    = 5;
    localparam int CFG_DATA_W = 15;

    localparam logic [STEPS_W-1:0] DIV_STEPS   = STEPS_W'(DIV_W);
    localparam logic [STEPS_W-1:0] SHORT_STEPS = STEPS_W'(MAG_W);

    localparam logic [N_W-1:0] N_RESET = N_W'(448);
    localparam logic [D_W-1:0] D_RESET = D_W'(360);

    typedef enum logic [0:0]
    {
        CFG_COUNTS_PER_REV  = 1'b0,
        CFG_DEGREES_PER_REV = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0]
    {
        FUNC_SAMPLE = 1'b0,
        FUNC_CLEAR  = 1'b1
    } func_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_WRAP,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed
    {
        logic                start;
        logic [STEPS_W-1:0]  steps;
    } div_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_stat_t;

    // Direction step from {previous pins, current pins}.
    function automatic logic signed [1:0] step_of(input logic [3:0] pattern);
        logic signed [1:0] s;
        unique case (pattern)
            4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default:                  s = 2'sd0;
        endcase
        return s;
    endfunction

    // Apply a sign to a remainder magnitude.
    function automatic logic signed [REM_W-1:0] signed_rem(input logic neg,
                                                           input logic [N_W-1:0] mag);
        logic signed [REM_W-1:0] m;
        m = signed'({2'b00, mag});
        return neg ? -m : m;
    endfunction

    // Fold a truncated remainder into [-n/2, n/2-1] for even n; zero when n is zero.
    function automatic logic signed [REM_W-1:0] wrap_rem(input logic signed [REM_W-1:0] r,
                                                         input logic [N_W-1:0] n);
        logic signed [REM_W-1:0] nn;
        logic signed [REM_W-1:0] half;
        logic signed [REM_W-1:0] res;
        nn   = signed'({2'b00, n});
        half = signed'({3'b000, n[N_W-1:1]});
        if (n == '0)
            res = '0;
        else if (r >= half)
            res = r - nn;
        else if (r < -half)
            res = r + nn;
        else
            res = r;
        return res;
    endfunction

endpackage

@@ src/qpt_if.sv @@
interface qpt_cmd_if;
    import qpt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [PINS_W-1:0]       pins;
    logic signed [REF_W-1:0] reference;

    modport source (output valid, func, pins, reference, input ready);
    modport sink (input valid, func, pins, reference, output ready);
endinterface

interface qpt_res_if;
    import qpt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic signed [ANG_W-1:0] angle;
    logic signed [DIF_W-1:0] difference;

    modport source (output valid, position, angle, difference, input ready);
    modport sink (input valid, position, angle, difference, output ready);
endinterface

@@ src/qpt_div.sv @@
`include "assert_macros.svh"

module qpt_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  qpt_pkg::div_req_t          req,
    input  logic [qpt_pkg::DIV_W-1:0]  dividend,
    input  logic [qpt_pkg::N_W-1:0]    divisor,
    output qpt_pkg::div_stat_t         stat,
    output logic [qpt_pkg::DIV_W-1:0]  quotient,
    output logic [qpt_pkg::N_W-1:0]    remainder
);
    import qpt_pkg::*;

    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [N_W-1:0]     rem_reg, rem_next;
    logic [N_W-1:0]     div_reg, div_next;
    logic [STEPS_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [N_W:0]       trial;
    logic [N_W:0]       trial_sub;
    logic               fits;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? trial_sub[N_W-1:0] : trial[N_W-1:0];
            cnt_next = cnt_reg - STEPS_W'(1);
            if (cnt_reg == STEPS_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `QPT_ASSERT(a_rem_bound, (busy_reg && div_reg != '0) |-> (rem_reg < div_reg), "partial remainder not below divisor")
    `QPT_ASSERT(a_no_restart, req.start |-> !busy_reg, "divider restarted while busy")
    `QPT_ASSERT(a_done_end, done_reg |-> ($past(busy_reg) && $past(cnt_reg) == STEPS_W'(1)), "done without a final step")

endmodule

@@ src/quadrature_position_tracker.sv @@
// Quadrature position tracker.
// cmd channel: one transaction per encoder sample (func = sample) or position
// clear (func = clear), with a signed reference position. result channel: one
// transaction per command with the wrapped position, the angle
// position * degrees_per_rev / counts_per_rev (truncated) and the wrapped
// difference reference - position. Config registers are written through
// wr_en / wr_index / wr_data; the user must write them only while no command
// is in flight, a rule that the block itself leaves unenforced. A sample runs
// the bit-serial dividers in turn: 16 steps to fold the new count into the
// revolution, then 27 steps for the angle quotient, with the 16-step
// difference remainder running alongside it; a clear skips the fold.
// One command is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, the result register holds and the finished work
// waits until it drains.
// Reset clears the position and previous pins and loads counts_per_rev = 448,
// degrees_per_rev = 360.
`include "assert_macros.svh"

module quadrature_position_tracker
(
    input  logic                             clk,
    input  logic                             rst_n,
    qpt_cmd_if.sink                          cmd,
    qpt_res_if.source                        result,
    input  logic                             wr_en,
    input  qpt_pkg::cfg_index_t              wr_index,
    input  logic [qpt_pkg::CFG_DATA_W-1:0]   wr_data
);
    import qpt_pkg::*;

    logic [N_W-1:0]           n_reg;
    logic [D_W-1:0]           d_reg;

    state_t                   state_reg, state_next;
    logic signed [CNT_W-1:0]  count_reg, count_next;
    logic [PINS_W-1:0]        prev_pins_reg, prev_pins_next;
    logic                     neg_reg, neg_next;
    logic signed [REF_W-1:0]  ref_reg, ref_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [REM_W-1:0]  dif_val_reg, dif_val_next;

    logic                     res_valid_reg, res_valid_next;
    logic signed [POS_W-1:0]  pos_out_reg, pos_out_next;
    logic signed [ANG_W-1:0]  ang_out_reg, ang_out_next;
    logic signed [DIF_W-1:0]  dif_out_reg, dif_out_next;

    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [REM_W-1:0]  count_wrap;
    logic signed [REM_W-1:0]  dif_wrap;
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [REM_W-1:0]  dif_abs;
    logic [ANG_W-1:0]         ang_q;
    logic                     load_out;

    div_req_t                 wrap_req, ang_req, dif_req;
    div_stat_t                wrap_stat, ang_stat, dif_stat;
    logic [DIV_W-1:0]         ang_dividend, dif_dividend;
    logic [DIV_W-1:0]         ang_quo;
    logic [N_W-1:0]           wrap_rem_mag, dif_rem_mag;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= N_RESET;
            d_reg <= D_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_COUNTS_PER_REV:  n_reg <= wr_data[N_W-1:0];
                CFG_DEGREES_PER_REV: d_reg <= wr_data[D_W-1:0];
                default:             n_reg <= n_reg;
            endcase
        end
    end

    assign sum     = SUM_W'(count_reg) + SUM_W'(step_of({prev_pins_reg, cmd.pins}));
    assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    assign prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign dif_abs  = dif_val_reg[REM_W-1] ? -dif_val_reg : dif_val_reg;

    assign ang_dividend = prod_abs[DIV_W-1:0];
    assign dif_dividend = {dif_abs[MAG_W-1:0], {(DIV_W-MAG_W){1'b0}}};

    assign count_wrap = wrap_rem(signed_rem(neg_reg, wrap_rem_mag), n_reg);
    assign dif_wrap   = wrap_rem(signed_rem(dif_val_reg[REM_W-1], dif_rem_mag), n_reg);
    assign ang_q      = ang_quo[ANG_W-1:0];

    assign load_out = (state_reg == ST_FIN) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        prev_pins_next = prev_pins_reg;
        neg_next       = neg_reg;
        ref_next       = ref_reg;
        prod_next      = prod_reg;
        dif_val_next   = dif_val_reg;
        wrap_req.start = 1'b0;
        wrap_req.steps = SHORT_STEPS;
        ang_req.start  = 1'b0;
        ang_req.steps  = DIV_STEPS;
        dif_req.start  = 1'b0;
        dif_req.steps  = SHORT_STEPS;
        cmd.ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    ref_next = cmd.reference;
                    if (cmd.func == FUNC_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        prev_pins_next = cmd.pins;
                        neg_next       = sum[SUM_W-1];
                        wrap_req.start = 1'b1;
                        state_next     = ST_WRAP;
                    end
                end
            end
            ST_WRAP:
            begin
                if (wrap_stat.done)
                begin
                    count_next = count_wrap[CNT_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next    = PROD_W'(count_reg) * PROD_W'(signed'({1'b0, d_reg}));
                dif_val_next = REM_W'(ref_reg) - REM_W'(count_reg);
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                ang_req.start = 1'b1;
                dif_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                // The angle divider runs longest; the difference result holds once done.
                if (ang_stat.done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        pos_out_next   = pos_out_reg;
        ang_out_next   = ang_out_reg;
        dif_out_next   = dif_out_reg;
        if (result.valid && result.ready)
            res_valid_next = 1'b0;
        if (load_out)
        begin
            res_valid_next = 1'b1;
            pos_out_next   = count_reg[POS_W-1:0];
            if (n_reg == '0)
                ang_out_next = '0;
            else
                ang_out_next = prod_reg[PROD_W-1] ? signed'(-ang_q) : signed'(ang_q);
            dif_out_next = dif_wrap[DIF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            prev_pins_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prev_pins_reg <= prev_pins_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        ref_reg     <= ref_next;
        prod_reg    <= prod_next;
        dif_val_reg <= dif_val_next;
        pos_out_reg <= pos_out_next;
        ang_out_reg <= ang_out_next;
        dif_out_reg <= dif_out_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.position   = pos_out_reg;
    assign result.angle      = ang_out_reg;
    assign result.difference = dif_out_reg;

    // Fold count + step into one revolution; only the remainder is used.
    qpt_div u_wrap_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (wrap_req),
        .dividend  ({sum_mag, {(DIV_W-MAG_W){1'b0}}}),
        .divisor   (n_reg),
        .stat      (wrap_stat),
        .quotient  (),
        .remainder (wrap_rem_mag)
    );

    qpt_div u_ang_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (ang_req),
        .dividend  (ang_dividend),
        .divisor   (n_reg),
        .stat      (ang_stat),
        .quotient  (ang_quo),
        .remainder ()
    );

    qpt_div u_dif_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (dif_req),
        .dividend  (dif_dividend),
        .divisor   (n_reg),
        .stat      (dif_stat),
        .quotient  (),
        .remainder (dif_rem_mag)
    );

    `QPT_ASSERT_NEXT(a_clear_zero, cmd.valid && cmd.ready && cmd.func == FUNC_CLEAR, count_reg == '0, "clear did not zero the position")
    `QPT_ASSERT(a_idle_quiet, (state_reg == ST_IDLE) |-> (!wrap_stat.busy && !ang_stat.busy && !dif_stat.busy), "divider busy while idle")
    `QPT_ASSERT(a_dif_first, ang_stat.done |-> !dif_stat.busy, "difference remainder not ready with the angle")

endmodule
